// ===== src/tgs_pkg.sv =====
package tgs_pkg;

    localparam int DATA_W  = 32;
    localparam int CELL_W  = 9;
    localparam int FRAC_W  = 16;
    localparam int COORD_W = CELL_W + FRAC_W;
    localparam int SIDX_W  = 15;
    localparam int ZY_W    = 17;
    localparam int IDX_W   = 25;
    localparam int PROD_W  = 64;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_SCALE_X,
        CFG_SCALE_Y,
        CFG_SCALE_Z,
        CFG_GRID_CELLS
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0][DATA_W-1:0] origin;
        logic [2:0][DATA_W-1:0] scale;
        logic [2:0][CELL_W-1:0] cells;
    } tgs_cfg_t;

    typedef struct packed {
        logic                   req_type;
        logic [SIDX_W-1:0]      sample_index;
        logic [DATA_W-1:0]      sample_value;
        logic [2:0][CELL_W-1:0] lo;
        logic [2:0][FRAC_W-1:0] frac;
    } tgs_item_t;

    // (a*(1-f) + b*f) rounded half up, f in 0.16
    function automatic logic [DATA_W-1:0] lerp16(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b,
                                                  input logic [FRAC_W-1:0] f);
        logic [FRAC_W:0] wf;
        logic [48:0]     acc;
        wf  = 17'h10000 - {1'b0, f};
        acc = 49'(a) * 49'(wf) + 49'(b) * 49'(f) + 49'd32768;
        return acc[47:16];
    endfunction

endpackage

// ===== src/tgs_front.sv =====
module tgs_front
    import tgs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tgs_cfg_t             cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [SIDX_W-1:0]    s_sample_index,
    input  logic [DATA_W-1:0]    s_sample_value,
    input  logic [DATA_W-1:0]    s_pos_x,
    input  logic [DATA_W-1:0]    s_pos_y,
    input  logic [DATA_W-1:0]    s_pos_z,
    input  logic                 q_full,
    output logic                 q_push,
    output tgs_item_t            q_item
);

    logic                   en;
    logic                   f0_valid_reg, f1_valid_reg, f2_valid_reg;
    logic                   f0_type_reg, f1_type_reg;
    logic [SIDX_W-1:0]      f0_idx_reg, f1_idx_reg;
    logic [DATA_W-1:0]      f0_val_reg, f1_val_reg;
    logic [2:0][DATA_W-1:0] f0_ud_reg;
    logic [2:0][PROD_W-1:0] f1_prod_reg;
    tgs_item_t              f2_item_reg, f2_item_next;
    logic [2:0][DATA_W-1:0] pos;
    logic [2:0][DATA_W-1:0] ud;
    logic [DATA_W:0]        diff [3];
    logic [47:0]            qv [3];
    logic [COORD_W-1:0]     lim [3];
    logic [COORD_W-1:0]     coord [3];

    assign en      = !f2_valid_reg || !q_full;
    assign s_ready = en;
    assign q_push  = f2_valid_reg && !q_full;
    assign q_item  = f2_item_reg;
    assign pos     = {s_pos_z, s_pos_y, s_pos_x};

    // offset from origin; non-positive offsets land on coordinate zero
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {pos[i][DATA_W-1], pos[i]} - {cfg.origin[i][DATA_W-1], cfg.origin[i]};
            ud[i]   = (!diff[i][DATA_W] && (diff[i] != '0)) ? diff[i][DATA_W-1:0] : '0;
        end
    end

    always_comb begin
        f2_item_next.req_type     = f1_type_reg;
        f2_item_next.sample_index = f1_idx_reg;
        f2_item_next.sample_value = f1_val_reg;
        for (int i = 0; i < 3; i++) begin
            qv[i]    = f1_prod_reg[i][63:16];
            lim[i]   = {cfg.cells[i], {FRAC_W{1'b0}}};
            coord[i] = (qv[i] > 48'(lim[i])) ? lim[i] : qv[i][COORD_W-1:0];
            f2_item_next.lo[i]   = coord[i][COORD_W-1:FRAC_W];
            f2_item_next.frac[i] = coord[i][FRAC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (en) begin
            f0_valid_reg <= s_valid;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f0_type_reg <= s_req_type;
            f0_idx_reg  <= s_sample_index;
            f0_val_reg  <= s_sample_value;
            f0_ud_reg   <= ud;
            f1_type_reg <= f0_type_reg;
            f1_idx_reg  <= f0_idx_reg;
            f1_val_reg  <= f0_val_reg;
            for (int i = 0; i < 3; i++) begin
                f1_prod_reg[i] <= PROD_W'(f0_ud_reg[i]) * PROD_W'(cfg.scale[i]);
            end
            f2_item_reg <= f2_item_next;
        end
    end

endmodule

// ===== src/tgs_fifo.sv =====
module tgs_fifo
    import tgs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  tgs_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output tgs_item_t head_item
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    tgs_item_t       store_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full       = (count_reg == (PW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(DEPTH)) else $error("queue count over depth");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("push into full queue");

endmodule

// ===== src/tgs_back.sv =====
module tgs_back
    import tgs_pkg::*;
#(
    parameter int GRID_POINTS = 32768
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [2:0][CELL_W-1:0] cells,
    input  logic                   head_valid,
    input  tgs_item_t              head_item,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [DATA_W-1:0]      m_depth_value
);

    localparam int AW = $clog2(GRID_POINTS);

    logic en;

    // stage 1: neighbour indices and z/y row products
    logic                   b1_valid_reg, b1_type_reg;
    logic [SIDX_W-1:0]      b1_idx_reg;
    logic [DATA_W-1:0]      b1_val_reg;
    logic [CELL_W-1:0]      b1_xlo_reg, b1_xhi_reg;
    logic [3:0][ZY_W-1:0]   b1_zy_reg;
    logic [2:0][FRAC_W-1:0] b1_frac_reg;
    // stage 2: corner addresses
    logic                   b2_valid_reg, b2_type_reg, b2_we_reg;
    logic [AW-1:0]          b2_waddr_reg;
    logic [DATA_W-1:0]      b2_wdata_reg;
    logic [7:0][AW-1:0]     b2_addr_reg;
    logic [7:0]             b2_oor_reg;
    logic [2:0][FRAC_W-1:0] b2_frac_reg;
    // stage 3: corner samples
    logic                   b3_valid_reg;
    logic [7:0]             b3_oor_reg;
    logic [DATA_W-1:0]      b3_rdata_reg [8];
    logic [2:0][FRAC_W-1:0] b3_frac_reg;
    // stages 4 and 5: blends along x then y
    logic                   b4_valid_reg, b5_valid_reg;
    logic [3:0][DATA_W-1:0] b4_ex_reg;
    logic [2:0][FRAC_W-1:0] b4_frac_reg;
    logic [1:0][DATA_W-1:0] b5_ey_reg;
    logic [FRAC_W-1:0]      b5_fz_reg;
    logic                   m_valid_reg;
    logic [DATA_W-1:0]      m_depth_value_reg;

    logic [2:0][CELL_W-1:0] hi;
    logic [3:0][ZY_W-1:0]   zy_next;
    logic [CELL_W:0]        sx, sy;
    logic [7:0][IDX_W-1:0]  idx;
    logic [7:0][AW-1:0]     addr_next;
    logic [7:0]             oor_next;
    logic [IDX_W-1:0]       load_idx;
    logic [DATA_W-1:0]      v [8];

    assign en            = !m_valid_reg || m_ready;
    assign pop           = en && head_valid;
    assign m_valid       = m_valid_reg;
    assign m_depth_value = m_depth_value_reg;
    assign sx            = {1'b0, cells[0]} + 1'b1;
    assign sy            = {1'b0, cells[1]} + 1'b1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hi[i] = (head_item.lo[i] == cells[i]) ? cells[i] : head_item.lo[i] + 1'b1;
        end
        for (int j = 0; j < 4; j++) begin
            zy_next[j] = ZY_W'(j[1] ? hi[2] : head_item.lo[2]) * ZY_W'(sy)
                       + ZY_W'(j[0] ? hi[1] : head_item.lo[1]);
        end
    end

    // corner k: bit 0 picks x, bit 1 picks y, bit 2 picks z
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            idx[k]       = IDX_W'(b1_zy_reg[k >> 1]) * IDX_W'(sx)
                         + IDX_W'(k[0] ? b1_xhi_reg : b1_xlo_reg);
            oor_next[k]  = (idx[k] >= IDX_W'(GRID_POINTS));
            addr_next[k] = idx[k][AW-1:0];
        end
        load_idx = IDX_W'(b1_idx_reg);
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            v[k] = b3_oor_reg[k] ? '0 : b3_rdata_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b2_we_reg    <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            b1_valid_reg <= head_valid;
            b2_valid_reg <= b1_valid_reg;
            b2_we_reg    <= b1_valid_reg && (b1_type_reg == REQ_LOAD)
                            && (load_idx < IDX_W'(GRID_POINTS));
            b3_valid_reg <= b2_valid_reg && (b2_type_reg == REQ_QUERY);
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
            m_valid_reg  <= b5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_type_reg  <= head_item.req_type;
            b1_idx_reg   <= head_item.sample_index;
            b1_val_reg   <= head_item.sample_value;
            b1_xlo_reg   <= head_item.lo[0];
            b1_xhi_reg   <= hi[0];
            b1_zy_reg    <= zy_next;
            b1_frac_reg  <= head_item.frac;
            b2_type_reg  <= b1_type_reg;
            b2_waddr_reg <= load_idx[AW-1:0];
            b2_wdata_reg <= b1_val_reg;
            b2_addr_reg  <= addr_next;
            b2_oor_reg   <= oor_next;
            b2_frac_reg  <= b1_frac_reg;
            b3_oor_reg   <= b2_oor_reg;
            b3_frac_reg  <= b2_frac_reg;
            for (int j = 0; j < 4; j++) begin
                b4_ex_reg[j] <= lerp16(v[2*j], v[2*j+1], b3_frac_reg[0]);
            end
            b4_frac_reg  <= b3_frac_reg;
            b5_ey_reg[0] <= lerp16(b4_ex_reg[0], b4_ex_reg[1], b4_frac_reg[1]);
            b5_ey_reg[1] <= lerp16(b4_ex_reg[2], b4_ex_reg[3], b4_frac_reg[1]);
            b5_fz_reg    <= b4_frac_reg[2];
            m_depth_value_reg <= lerp16(b5_ey_reg[0], b5_ey_reg[1], b5_fz_reg);
        end
    end

    // eight replicated sample stores, one read port each, all written together
    for (genvar g = 0; g < 8; g++) begin : g_bank
        logic [DATA_W-1:0] mem [GRID_POINTS];
        always_ff @(posedge aclk) begin
            if (en) begin
                if (b2_we_reg) begin
                    mem[b2_waddr_reg] <= b2_wdata_reg;
                end
                b3_rdata_reg[g] <= mem[b2_addr_reg[g]];
            end
        end
    end

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && b2_valid_reg && b2_type_reg == REQ_LOAD) |=> !b3_valid_reg)
        else $error("load beat reached blend stages");
    a_write_only_load: assert property (@(posedge aclk) disable iff (!aresetn)
        b2_we_reg |-> b2_valid_reg && b2_type_reg == REQ_LOAD)
        else $error("store write without load beat");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(b5_ey_reg) && $stable(b5_valid_reg))
        else $error("pipeline moved under stall");

endmodule

// ===== src/trilinear_grid_sampler_core.sv =====
// Path: an input beat passes the front stages, the item queue and the back stages to the result register.
// Throughput: one beat per cycle while m_ready does not stall the pipeline; the eight corner reads come from eight
// replicated sample stores, each with its own read port.
// Reset: synchronous active-low aresetn clears pipeline and queue control and
// loads the register defaults; the sample store is not cleared.
module trilinear_grid_sampler_core
    import tgs_pkg::*;
#(
    parameter int GRID_POINTS = 32768,
    parameter int MAX_CELLS   = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [SIDX_W-1:0]    s_sample_index,
    input  logic [DATA_W-1:0]    s_sample_value,
    input  logic [DATA_W-1:0]    s_pos_x,
    input  logic [DATA_W-1:0]    s_pos_y,
    input  logic [DATA_W-1:0]    s_pos_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_depth_value
);

    logic [2:0][DATA_W-1:0]   origin_reg;
    logic [2:0][DATA_W-1:0]   scale_reg;
    logic [3*CELL_W-1:0]      grid_cells_reg;
    tgs_cfg_t                 cfg;
    logic [CELL_W-1:0]        raw [3];
    logic                     q_full, q_push, q_pop, q_valid;
    tgs_item_t                q_in, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg     <= '0;
            scale_reg      <= {3{32'h0001_0000}};
            grid_cells_reg <= {9'd1, 9'd1, 9'd1};
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X:   origin_reg[0]  <= cfg_wdata;
                CFG_ORIGIN_Y:   origin_reg[1]  <= cfg_wdata;
                CFG_ORIGIN_Z:   origin_reg[2]  <= cfg_wdata;
                CFG_SCALE_X:    scale_reg[0]   <= cfg_wdata;
                CFG_SCALE_Y:    scale_reg[1]   <= cfg_wdata;
                CFG_SCALE_Z:    scale_reg[2]   <= cfg_wdata;
                CFG_GRID_CELLS: grid_cells_reg <= cfg_wdata[3*CELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.origin = origin_reg;
        cfg.scale  = scale_reg;
        for (int i = 0; i < 3; i++) begin
            raw[i] = grid_cells_reg[i*CELL_W +: CELL_W];
            if (raw[i] == '0) begin
                cfg.cells[i] = CELL_W'(1);
            end else if (raw[i] > CELL_W'(MAX_CELLS)) begin
                cfg.cells[i] = CELL_W'(MAX_CELLS);
            end else begin
                cfg.cells[i] = raw[i];
            end
        end
    end

    tgs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_sample_index (s_sample_index),
        .s_sample_value (s_sample_value),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_in)
    );

    tgs_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    tgs_back #(
        .GRID_POINTS (GRID_POINTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cells         (cfg.cells),
        .head_valid    (q_valid),
        .head_item     (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_depth_value (m_depth_value)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import tgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_N = 32768;

    class depth_scoreboard;
        logic [DATA_W-1:0] grid [GRID_N];
        bit                written [GRID_N];
        longint            org [3];
        longint unsigned   scl [3];
        logic [26:0]       cells_reg;
        logic [DATA_W-1:0] depth_q [$];
        int                errors;

        function new();
            errors = 0;
            reset_cfg();
            foreach (written[i]) written[i] = 0;
        endfunction

        function void reset_cfg();
            for (int a = 0; a < 3; a++) begin
                org[a] = 0;
                scl[a] = 65536;
            end
            cells_reg = 27'd262657;
        endfunction

        function void set_cfg(cfg_idx_t idx, logic [DATA_W-1:0] v);
            case (idx)
                CFG_ORIGIN_X:   org[0] = longint'($signed(v));
                CFG_ORIGIN_Y:   org[1] = longint'($signed(v));
                CFG_ORIGIN_Z:   org[2] = longint'($signed(v));
                CFG_SCALE_X:    scl[0] = 64'(v);
                CFG_SCALE_Y:    scl[1] = 64'(v);
                CFG_SCALE_Z:    scl[2] = 64'(v);
                CFG_GRID_CELLS: cells_reg = v[26:0];
                default: ;
            endcase
        endfunction

        function longint unsigned cell_count(int a);
            longint unsigned c;
            c = 64'((cells_reg >> (9 * a)) & 27'h1FF);
            if (c < 1) c = 1;
            if (c > 31) c = 31;
            return c;
        endfunction

        function longint unsigned axis_coord(int a, logic [DATA_W-1:0] p);
            longint          d;
            longint unsigned ud, q, lim;
            d = longint'($signed(p)) - org[a];
            if (d <= 0) return 0;
            ud  = d;
            q   = ud * (scl[a] >> 16) + ((ud * (scl[a] & 64'hFFFF)) >> 16);
            lim = cell_count(a) << 16;
            return (q > lim) ? lim : q;
        endfunction

        function void corners(input logic [DATA_W-1:0] p [3],
                              output longint unsigned idx [8],
                              output longint unsigned fr [3]);
            longint unsigned lo [3], hi [3], cn [3], c, x, y, z;
            for (int a = 0; a < 3; a++) begin
                cn[a] = cell_count(a);
                c     = axis_coord(a, p[a]);
                lo[a] = c >> 16;
                fr[a] = c & 64'hFFFF;
                hi[a] = (lo[a] + 1 > cn[a]) ? cn[a] : lo[a] + 1;
            end
            for (int k = 0; k < 8; k++) begin
                x = k[0] ? hi[0] : lo[0];
                y = k[1] ? hi[1] : lo[1];
                z = k[2] ? hi[2] : lo[2];
                idx[k] = (z * (cn[1] + 1) + y) * (cn[0] + 1) + x;
            end
        endfunction

        function longint unsigned blend(longint unsigned a, longint unsigned b,
                                        longint unsigned f);
            return (a * (65536 - f) + b * f + 32768) >> 16;
        endfunction

        function longint unsigned grid_rd(longint unsigned i);
            return (i < GRID_N) ? longint'(grid[i]) : 0;
        endfunction

        function void note_beat(logic rt, logic [SIDX_W-1:0] si, logic [DATA_W-1:0] sv,
                                logic [DATA_W-1:0] p [3]);
            longint unsigned idx [8], fr [3], v [8], ex [4], ey [2];
            if (rt == REQ_LOAD) begin
                grid[si]    = sv;
                written[si] = 1;
                return;
            end
            corners(p, idx, fr);
            for (int k = 0; k < 8; k++) v[k] = grid_rd(idx[k]);
            for (int k = 0; k < 4; k++) ex[k] = blend(v[2*k], v[2*k+1], fr[0]);
            ey[0] = blend(ex[0], ex[1], fr[1]);
            ey[1] = blend(ex[2], ex[3], fr[1]);
            depth_q = {depth_q, DATA_W'(blend(ey[0], ey[1], fr[2]))};
        endfunction

        function void check_depth(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (depth_q.size() == 0) begin
                $display("%t unexpected beat: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = depth_q.pop_front();
            if (got !== want) begin
                $display("%t depth_value mismatch: expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [2:0]        cfg_index;
    logic [DATA_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    logic [SIDX_W-1:0] s_sample_index;
    logic [DATA_W-1:0] s_sample_value;
    logic [DATA_W-1:0] s_pos_x;
    logic [DATA_W-1:0] s_pos_y;
    logic [DATA_W-1:0] s_pos_z;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_depth_value;

    depth_scoreboard sb;
    bit              burst;
    bit              hold_now;
    int              sent;

    trilinear_grid_sampler_core i_dut (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("[trilinear_grid_sampler_core] ERROR");
        $finish;
    end

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) sb.check_depth(m_depth_value);

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    // receiver
    initial begin
        int n;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            n = draw_gap();
            if (hold_now) begin
                hold_now = 0;
                n = 400;
            end
            repeat (n) begin
                @(negedge aclk);
                m_ready <= 0;
            end
            @(negedge aclk);
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_beat(logic rt, logic [SIDX_W-1:0] si, logic [DATA_W-1:0] sv,
                             logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                             logic [DATA_W-1:0] pz);
        logic [DATA_W-1:0] p [3];
        int n;
        p[0] = px; p[1] = py; p[2] = pz;
        n = draw_gap();
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 0;
        end
        @(negedge aclk);
        s_valid        <= 1;
        s_req_type     <= rt;
        s_sample_index <= si;
        s_sample_value <= sv;
        s_pos_x        <= px;
        s_pos_y        <= py;
        s_pos_z        <= pz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_beat(rt, si, sv, p);
        sent++;
    endtask

    task automatic send_load(int unsigned idx, logic [DATA_W-1:0] v);
        send_beat(REQ_LOAD, SIDX_W'(idx), v, $urandom, $urandom, $urandom);
    endtask

    // loads any unwritten corner first, so no query reads an empty entry
    task automatic send_query(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                              logic [DATA_W-1:0] pz);
        logic [DATA_W-1:0] p [3];
        longint unsigned   idx [8], fr [3];
        p[0] = px; p[1] = py; p[2] = pz;
        sb.corners(p, idx, fr);
        for (int k = 0; k < 8; k++)
            if (!sb.written[idx[k]]) send_load(int'(idx[k]), $urandom);
        send_beat(REQ_QUERY, SIDX_W'($urandom), $urandom, px, py, pz);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_valid <= 0;
        while (sb.depth_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        if (sb.depth_q.size() != 0) begin
            $display("[trilinear_grid_sampler_core] ERROR");
            $finish;
        end
        repeat (14) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        sb.set_cfg(idx, v);
    endtask

    task automatic set_phase(logic [DATA_W-1:0] o [3], logic [DATA_W-1:0] s [3],
                             logic [26:0] cells);
        drain();
        write_reg(CFG_ORIGIN_X, o[0]);
        write_reg(CFG_ORIGIN_Y, o[1]);
        write_reg(CFG_ORIGIN_Z, o[2]);
        write_reg(CFG_SCALE_X, s[0]);
        write_reg(CFG_SCALE_Y, s[1]);
        write_reg(CFG_SCALE_Z, s[2]);
        write_reg(CFG_GRID_CELLS, DATA_W'(cells));
    endtask

    function automatic logic [DATA_W-1:0] pick_pos(int a);
        longint unsigned span;
        int unsigned     r;
        r = $urandom_range(0, 99);
        if (r < 25) return $urandom;
        if (r < 40) return DATA_W'(sb.org[a] + $signed($urandom_range(0, 8)) - 4);
        if (sb.scl[a] == 0) span = 32'h10000;
        else span = ((sb.cell_count(a) + 1) << 32) / sb.scl[a];
        if (span > 32'h7FFFFFFF) span = 32'h7FFFFFFF;
        if (span == 0) span = 1;
        return DATA_W'(sb.org[a] + longint'($urandom_range(0, int'(span))));
    endfunction

    // count is in beats, corner loads included
    task automatic random_items(int count);
        int stop, i;
        stop = sent + count;
        i    = 0;
        while (sent < stop) begin
            if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 35) send_load($urandom_range(0, 32767), $urandom);
            else send_query(pick_pos(0), pick_pos(1), pick_pos(2));
            i++;
        end
    endtask

    initial begin
        logic [DATA_W-1:0] o [3], s [3];
        int                stop;
        sb = new();
        aresetn        = 0;
        cfg_wr_en      = 0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 0;
        s_req_type     = REQ_LOAD;
        s_sample_index = '0;
        s_sample_value = '0;
        s_pos_x        = '0;
        s_pos_y        = '0;
        s_pos_z        = '0;
        burst          = 0;
        hold_now       = 0;
        sent           = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1;

        // directed, default 1x1x1 cell grid
        send_load(0, 32'h0);
        send_load(1, 32'hFFFFFFFF);
        send_load(2, 32'h00010000);
        send_load(3, 32'hFFFFFFFF);
        send_load(4, 32'h80000000);
        send_load(5, 32'h0);
        send_load(6, 32'h7FFFFFFF);
        send_load(7, 32'hFFFFFFFF);
        send_load(32767, 32'h12345678);
        send_query(32'h0, 32'h0, 32'h0);
        send_query(32'h80000000, 32'h80000000, 32'h80000000);
        send_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_query(32'h00008000, 32'h00008000, 32'h00008000);
        send_query(32'h00010000, 32'h00000001, 32'h0000FFFF);
        send_query(32'h00004000, 32'h0000C000, 32'h00020000);
        send_query(32'hFFFFFFFF, 32'h00008000, 32'h00000001);

        // cell counts of zero saturate to one; scale zero pins the x axis
        o[0] = 32'h7FFFFFFF; o[1] = 32'h80000000; o[2] = 32'h0;
        s[0] = 32'h0; s[1] = 32'hFFFFFFFF; s[2] = 32'h00010000;
        set_phase(o, s, 27'd0);
        send_query(32'h80000000, 32'h7FFFFFFF, 32'h00008000);
        send_query(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        random_items(60);

        // largest grid, counts over the limit
        o[0] = 32'h0; o[1] = 32'hFFF00000; o[2] = 32'h00100000;
        s[0] = 32'h00010000; s[1] = 32'h00020000; s[2] = 32'h00008000;
        set_phase(o, s, 27'h7FFFFFF);
        send_query(32'h001F0000, 32'h00000000, 32'h002F0000);
        random_items(220);

        // receiver holds off while the sender keeps going
        hold_now = 1;
        burst    = 1;
        stop     = sent + 60;
        while (sent < stop) send_query(pick_pos(0), pick_pos(1), pick_pos(2));
        burst = 0;
        drain();
        random_items(100);

        o[0] = $urandom; o[1] = $urandom; o[2] = $urandom;
        s[0] = $urandom_range(32'h4000, 32'h40000);
        s[1] = $urandom_range(32'h4000, 32'h40000);
        s[2] = $urandom_range(32'h4000, 32'h40000);
        set_phase(o, s, {9'd3, 9'd7, 9'd31});
        random_items(200);

        o[0] = 32'h80000000; o[1] = 32'h7FFFFFFF; o[2] = 32'hFFFF0000;
        s[0] = 32'hFFFFFFFF; s[1] = 32'h00000001; s[2] = 32'h00030000;
        set_phase(o, s, {9'd2, 9'd200, 9'd5});
        random_items(150);

        drain();
        if (sb.errors == 0)
            $display("[trilinear_grid_sampler_core] OK");
        else
            $display("[trilinear_grid_sampler_core] ERROR");
        $finish;
    end

endmodule

// ===== trilinear_grid_sampler_core.f =====
src/tgs_pkg.sv
src/tgs_front.sv
src/tgs_fifo.sv
src/tgs_back.sv
src/trilinear_grid_sampler_core.sv
verif/testbench.sv
